@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the power core RTL.
// Included by fpip_fpu.sv and fp64_integer_power_core.sv; synthesis sees empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// The condition must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

@@ rtl/core/fpip_pkg.sv @@
// Types and constants for the binary64 integer power core.
// Used by fpip_fpu.sv and fp64_integer_power_core.sv; no dependencies.
package fpip_pkg;

    typedef enum logic [2:0] {
        T_IDLE,
        T_RCP,
        T_SKIP,
        T_SQ,
        T_MB,
        T_DONE
    } top_state_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_DNORM,
        F_DIV,
        F_NORM,
        F_DENORM,
        F_ROUND
    } fpu_state_t;

    typedef struct packed {
        logic start;
        logic recip;
    } fpu_req_t;

    typedef struct packed {
        logic done;
    } fpu_rsp_t;

    localparam logic [63:0] FP_ONE         = 64'h3FF0_0000_0000_0000;
    localparam logic [63:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [63:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;
    localparam logic [10:0] EXP_ALL_ONES   = 11'h7FF;

    // Exponent offsets for the unrounded value held with its top bit at 105.
    localparam logic signed [13:0] MUL_BIAS    = 14'sd1022;
    localparam logic signed [13:0] RECIP_BIAS  = 14'sd2046;
    localparam logic signed [13:0] UFLOW_LIMIT = -14'sd60;
    localparam logic signed [13:0] EXP_OVF     = 14'sd2047;

    localparam logic [1:0] MUL_LAST_PP = 2'd3;
    localparam logic [5:0] DIV_LAST    = 6'd54;

endpackage

@@ rtl/core/fp64_integer_power_core.sv @@
// Binary64 base raised to a signed integer power, by square and multiply.
// Steps: a reciprocal of the base for a negative exponent, a skip over leading zero bits,
// then a square and an optional multiply per remaining bit, each on the shared unit.
// Throughput: one item at a time; the next word is taken once the result is registered.
// Reset (asynchronous, active low) clears the sequencer and output valid only.
// Depends on fpip_pkg, fpip_fpu and assert_macros.svh.
`include "assert_macros.svh"

module fp64_integer_power_core
    import fpip_pkg::*;
#(
    parameter int EXP_WIDTH = 32
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [63:0]                 base_bits,
    input  logic signed [EXP_WIDTH-1:0] exponent,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [63:0]                 result_bits
);

    localparam int CNT_W = $clog2(EXP_WIDTH + 1);

    top_state_t           state_reg, state_next;
    logic [63:0]          base_reg, base_next;
    logic [63:0]          acc_reg, acc_next;
    logic [EXP_WIDTH-1:0] mag_reg, mag_next;
    logic [CNT_W-1:0]     left_reg, left_next;
    logic                 issued_reg, issued_next;
    logic                 out_valid_reg, out_valid_next;
    logic [63:0]          out_data_reg, out_data_next;

    fpu_req_t    fpu_req;
    fpu_rsp_t    fpu_rsp;
    logic [63:0] fpu_a, fpu_b, fpu_result;

    logic [EXP_WIDTH-1:0] exp_u, mag_in;
    logic                 accept;

    assign exp_u    = $unsigned(exponent);
    assign mag_in   = exp_u[EXP_WIDTH-1] ? (~exp_u + {{(EXP_WIDTH-1){1'b0}}, 1'b1}) : exp_u;
    assign in_stall = (state_reg != T_IDLE);
    assign accept   = in_valid && !in_stall;

    // Operand routing to the shared unit.
    assign fpu_a         = (state_reg == T_RCP) ? base_reg : acc_reg;
    assign fpu_b         = (state_reg == T_SQ) ? acc_reg : base_reg;
    assign fpu_req.start = ((state_reg == T_RCP) || (state_reg == T_SQ) || (state_reg == T_MB))
                           && !issued_reg;
    assign fpu_req.recip = (state_reg == T_RCP);

    fpip_fpu u_fpu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (fpu_req),
        .op_a   (fpu_a),
        .op_b   (fpu_b),
        .rsp    (fpu_rsp),
        .result (fpu_result)
    );

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            issued_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            issued_reg    <= issued_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        acc_reg      <= acc_next;
        mag_reg      <= mag_next;
        left_reg     <= left_next;
        out_data_reg <= out_data_next;
    end

    // Sequencer: optional reciprocal, skip leading zeros, then square and optionally multiply per bit.
    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        acc_next       = acc_reg;
        mag_next       = mag_reg;
        left_next      = left_reg;
        issued_next    = issued_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;

        unique case (state_reg)
            T_IDLE:
            begin
                if (accept)
                begin
                    base_next   = base_bits;
                    mag_next    = mag_in;
                    left_next   = CNT_W'(EXP_WIDTH);
                    acc_next    = FP_ONE;
                    issued_next = 1'b0;
                    if (mag_in == '0)
                    begin
                        state_next = T_DONE;
                    end
                    else if (exp_u[EXP_WIDTH-1])
                    begin
                        state_next = T_RCP;
                    end
                    else
                    begin
                        state_next = T_SKIP;
                    end
                end
            end

            T_RCP:
            begin
                issued_next = 1'b1;
                if (fpu_rsp.done)
                begin
                    base_next   = fpu_result;
                    issued_next = 1'b0;
                    state_next  = T_SKIP;
                end
            end

            T_SKIP:
            begin
                if (mag_reg[EXP_WIDTH-1])
                begin
                    state_next = T_SQ;
                end
                else
                begin
                    mag_next  = mag_reg << 1;
                    left_next = left_reg - 1'b1;
                end
            end

            T_SQ:
            begin
                issued_next = 1'b1;
                if (fpu_rsp.done)
                begin
                    acc_next    = fpu_result;
                    issued_next = 1'b0;
                    if (mag_reg[EXP_WIDTH-1])
                    begin
                        state_next = T_MB;
                    end
                    else
                    begin
                        mag_next   = mag_reg << 1;
                        left_next  = left_reg - 1'b1;
                        state_next = (left_reg == CNT_W'(1)) ? T_DONE : T_SQ;
                    end
                end
            end

            T_MB:
            begin
                issued_next = 1'b1;
                if (fpu_rsp.done)
                begin
                    acc_next    = fpu_result;
                    issued_next = 1'b0;
                    mag_next    = mag_reg << 1;
                    left_next   = left_reg - 1'b1;
                    state_next  = (left_reg == CNT_W'(1)) ? T_DONE : T_SQ;
                end
            end

            T_DONE:
            begin
                // The output register takes the word once the last one has gone.
                if (!out_valid_reg || !out_stall)
                begin
                    out_data_next  = acc_reg;
                    out_valid_next = 1'b1;
                    state_next     = T_IDLE;
                end
            end

            default:
            begin
                state_next = T_IDLE;
            end
        endcase
    end

    assign out_valid   = out_valid_reg;
    assign result_bits = out_data_reg;

    `ASSERT_CLK(a_done_in_op, clk, rst_n,
                fpu_rsp.done |-> (state_reg == T_RCP || state_reg == T_SQ || state_reg == T_MB),
                "unit result outside an operation")
    `ASSERT_NEVER(a_sq_no_bits, clk, rst_n, (state_reg == T_SQ) && (left_reg == '0),
                  "squaring with no bits left")
    `ASSERT_CLK(a_accept_busy, clk, rst_n, accept |=> in_stall, "accepted word did not busy the core")

endmodule

@@ rtl/core/fpip_fpu.sv @@
// Shared binary64 unit: multiply or reciprocal, round to nearest-even, IEEE specials.
// Depends on fpip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fpip_fpu
    import fpip_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  fpu_req_t    req,
    input  logic [63:0] op_a,
    input  logic [63:0] op_b,
    output fpu_rsp_t    rsp,
    output logic [63:0] result
);

    fpu_state_t          state_reg, state_next;
    logic                sign_reg, sign_next;
    logic signed [13:0]  bexp_reg, bexp_next;
    logic [105:0]        prod_reg, prod_next;
    logic [52:0]         ma_reg, ma_next;
    logic [52:0]         mb_reg, mb_next;
    logic [53:0]         rem_reg, rem_next;
    logic [53:0]         quo_reg, quo_next;
    logic [5:0]          cnt_reg, cnt_next;
    logic [63:0]         result_reg, result_next;
    logic                done_reg, done_next;

    // Operand unpacking.
    logic        a_sign, b_sign, a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [10:0] a_exp, b_exp, a_eff, b_eff;
    logic [52:0] a_mant, b_mant;

    assign a_sign = op_a[63];
    assign b_sign = op_b[63];
    assign a_exp  = op_a[62:52];
    assign b_exp  = op_b[62:52];
    assign a_nan  = (a_exp == EXP_ALL_ONES) && (op_a[51:0] != '0);
    assign b_nan  = (b_exp == EXP_ALL_ONES) && (op_b[51:0] != '0);
    assign a_inf  = (a_exp == EXP_ALL_ONES) && (op_a[51:0] == '0);
    assign b_inf  = (b_exp == EXP_ALL_ONES) && (op_b[51:0] == '0);
    assign a_zero = (a_exp == '0) && (op_a[51:0] == '0);
    assign b_zero = (b_exp == '0) && (op_b[51:0] == '0);
    assign a_mant = {a_exp != '0, op_a[51:0]};
    assign b_mant = {b_exp != '0, op_b[51:0]};
    assign a_eff  = (a_exp == '0) ? 11'd1 : a_exp;
    assign b_eff  = (b_exp == '0) ? 11'd1 : b_exp;

    // Partial product of one 27-bit slice of each mantissa.
    logic [26:0]  a_part, b_part;
    logic [53:0]  pp;
    logic [105:0] pp_ext, pp_shift;

    assign a_part = cnt_reg[1] ? {1'b0, ma_reg[52:27]} : ma_reg[26:0];
    assign b_part = cnt_reg[0] ? {1'b0, mb_reg[52:27]} : mb_reg[26:0];
    assign pp     = a_part * b_part;
    assign pp_ext = {52'b0, pp};

    always_comb
    begin
        case (cnt_reg[1:0]) inside
            2'd0:       pp_shift = pp_ext;
            2'd1, 2'd2: pp_shift = pp_ext << 27;
            default:    pp_shift = pp_ext << 54;
        endcase
    end

    // One restoring division step.
    logic        div_ge;
    logic [53:0] div_diff;

    assign div_ge   = rem_reg >= {1'b0, mb_reg};
    assign div_diff = div_ge ? (rem_reg - {1'b0, mb_reg}) : rem_reg;

    // Rounding of the normalised value.
    logic [52:0]        rnd_m;
    logic               rnd_up;
    logic [53:0]        rnd_mr;
    logic signed [13:0] rnd_e;

    assign rnd_m  = prod_reg[105:53];
    assign rnd_up = prod_reg[52] & ((|prod_reg[51:0]) | rnd_m[0]);
    assign rnd_mr = {1'b0, rnd_m} + {53'b0, rnd_up};
    assign rnd_e  = rnd_mr[53] ? (bexp_reg + 14'sd1) : (rnd_mr[52] ? bexp_reg : 14'sd0);

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        sign_reg   <= sign_next;
        bexp_reg   <= bexp_next;
        prod_reg   <= prod_next;
        ma_reg     <= ma_next;
        mb_reg     <= mb_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
    end

    // Sequencer and datapath next state.
    always_comb
    begin
        state_next  = state_reg;
        sign_next   = sign_reg;
        bexp_next   = bexp_reg;
        prod_next   = prod_reg;
        ma_next     = ma_reg;
        mb_next     = mb_reg;
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        done_next   = 1'b0;

        unique case (state_reg)
            F_IDLE:
            begin
                if (req.start)
                begin
                    if (req.recip)
                    begin
                        sign_next = a_sign;
                        if (a_nan)
                        begin
                            result_next = op_a | FP_QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if (a_inf)
                        begin
                            result_next = {a_sign, 63'b0};
                            done_next   = 1'b1;
                        end
                        else if (a_zero)
                        begin
                            result_next = {a_sign, EXP_ALL_ONES, 52'b0};
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            mb_next    = a_mant;
                            bexp_next  = RECIP_BIAS - $signed({3'b0, a_eff});
                            state_next = F_DNORM;
                        end
                    end
                    else
                    begin
                        sign_next = a_sign ^ b_sign;
                        if (a_nan)
                        begin
                            result_next = op_a | FP_QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if (b_nan)
                        begin
                            result_next = op_b | FP_QUIET_BIT;
                            done_next   = 1'b1;
                        end
                        else if ((a_inf && b_zero) || (a_zero && b_inf))
                        begin
                            result_next = FP_DEFAULT_NAN;
                            done_next   = 1'b1;
                        end
                        else if (a_inf || b_inf)
                        begin
                            result_next = {a_sign ^ b_sign, EXP_ALL_ONES, 52'b0};
                            done_next   = 1'b1;
                        end
                        else if (a_zero || b_zero)
                        begin
                            result_next = {a_sign ^ b_sign, 63'b0};
                            done_next   = 1'b1;
                        end
                        else
                        begin
                            ma_next    = a_mant;
                            mb_next    = b_mant;
                            bexp_next  = $signed({3'b0, a_eff}) + $signed({3'b0, b_eff})
                                         - MUL_BIAS;
                            prod_next  = '0;
                            cnt_next   = '0;
                            state_next = F_MUL;
                        end
                    end
                end
            end

            F_MUL:
            begin
                prod_next = prod_reg + pp_shift;
                cnt_next  = cnt_reg + 6'd1;
                if (cnt_reg[1:0] == MUL_LAST_PP)
                begin
                    state_next = F_NORM;
                end
            end

            F_DNORM:
            begin
                if (mb_reg[52])
                begin
                    rem_next   = 54'd1 << 52;
                    cnt_next   = '0;
                    state_next = F_DIV;
                end
                else
                begin
                    mb_next   = {mb_reg[51:0], 1'b0};
                    bexp_next = bexp_reg + 14'sd1;
                end
            end

            F_DIV:
            begin
                rem_next = {div_diff[52:0], 1'b0};
                quo_next = {quo_reg[52:0], div_ge};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == DIV_LAST)
                begin
                    prod_next  = {quo_reg, div_ge, |div_diff[52:0], 50'b0};
                    state_next = F_NORM;
                end
            end

            F_NORM:
            begin
                if (prod_reg[105])
                begin
                    state_next = F_DENORM;
                end
                else
                begin
                    prod_next = {prod_reg[104:0], 1'b0};
                    bexp_next = bexp_reg - 14'sd1;
                end
            end

            F_DENORM:
            begin
                // Far below the subnormal range only a sticky bit survives.
                if (bexp_reg < UFLOW_LIMIT)
                begin
                    prod_next  = 106'd1;
                    bexp_next  = 14'sd1;
                    state_next = F_ROUND;
                end
                else if (bexp_reg < 14'sd1)
                begin
                    prod_next = {1'b0, prod_reg[105:2], prod_reg[1] | prod_reg[0]};
                    bexp_next = bexp_reg + 14'sd1;
                end
                else
                begin
                    state_next = F_ROUND;
                end
            end

            F_ROUND:
            begin
                if (rnd_e >= EXP_OVF)
                begin
                    result_next = {sign_reg, EXP_ALL_ONES, 52'b0};
                end
                else if (rnd_mr[53])
                begin
                    result_next = {sign_reg, rnd_e[10:0], 52'b0};
                end
                else
                begin
                    result_next = {sign_reg, rnd_e[10:0], rnd_mr[51:0]};
                end
                done_next  = 1'b1;
                state_next = F_IDLE;
            end

            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    assign rsp.done = done_reg;
    assign result   = result_reg;

    `ASSERT_CLK(a_done_pulse, clk, rst_n, rsp.done |=> !rsp.done, "done held for two cycles")
    `ASSERT_CLK(a_start_idle, clk, rst_n, req.start |-> (state_reg == F_IDLE), "start while busy")
    `ASSERT_NEVER(a_norm_zero, clk, rst_n, (state_reg == F_NORM) && (prod_reg == '0),
                  "normalising a zero product")

endmodule
